// File: rtl/brb_pkg.sv
`timescale 1ns / 1ps

package brb_pkg;

  typedef logic [1:0] cmd_t;
  typedef logic [1:0] status_t;

  localparam cmd_t CMD_WRITE   = 2'd0;
  localparam cmd_t CMD_READ    = 2'd1;
  localparam cmd_t CMD_CLEAR   = 2'd2;
  localparam cmd_t CMD_MEASURE = 2'd3;

  localparam status_t ST_OK     = 2'd0;
  localparam status_t ST_WR_REJ = 2'd1;
  localparam status_t ST_RD_REJ = 2'd2;

  // most results that a single read may produce
  localparam int unsigned MAX_RES = 32;

endpackage

// File: rtl/byte_ring_buffer_msg_len_unit.sv
`timescale 1ns / 1ps
// Write, clear, rejected or empty read and measure of an empty store give their
// single result in the cycle after the item transfer. A read of N bytes fetches each byte
// into the registered memory read data and then loads it into the output register, one
// byte per cycle while the output is not stalled. A measure walks the store one entry per
// cycle from the read index. Writes stream one per cycle while the output is not stalled.
// Reset (rst, synchronous) clears state, indexes, fill count, drop flag and result_valid; store and output data keep.
module byte_ring_buffer_msg_len_unit #(
  parameter int DEPTH = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  output logic       item_stall,
  input  logic [1:0] cmd,
  input  logic [7:0] wr_byte,
  input  logic [5:0] xfer_count,
  input  logic       first_of_xfer,
  output logic       result_valid,
  input  logic       result_stall,
  output logic [7:0] rd_byte,
  output logic [1:0] status,
  output logic [5:0] msg_len,
  output logic [5:0] readable_count,
  output logic [5:0] writeable_count,
  output logic       last_of_run
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = ((CW > 6) ? CW : 6) + 1;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    ptr_inc = (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  logic [7:0] store [DEPTH];
  logic [7:0] mem_rdata;
  logic          mem_we;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;

  logic [1:0]    state, state_next;
  logic [AW-1:0] rd_index, rd_index_next;
  logic [AW-1:0] wr_index, wr_index_next;
  logic [CW-1:0] fill, fill_next;
  logic          dropping, dropping_next;
  logic [AW-1:0] work_ptr, work_ptr_next;
  logic [CW-1:0] rem, rem_next;
  logic [CW-1:0] scan_idx, scan_idx_next;

  logic          out_free;
  logic          accept;
  logic          load;
  logic [7:0]    ld_byte;
  brb_pkg::status_t ld_status;
  logic [CW-1:0] ld_len;
  logic          ld_last;

  logic [XW-1:0] cnt_x;
  logic [XW-1:0] fill_x;
  logic [XW-1:0] free_x;
  logic          full;
  logic          drop_now;
  logic [AW:0]   rd_sum;
  logic          scan_hit;

  assign out_free   = !result_valid || !result_stall;
  assign item_stall = (state != S_IDLE) || !out_free;
  assign accept     = item_valid && !item_stall;

  assign cnt_x    = XW'(xfer_count);
  assign fill_x   = XW'(fill);
  assign free_x   = XW'(DEPTH) - fill_x;
  assign full     = (fill == CW'(DEPTH));
  assign drop_now = first_of_xfer ? (cnt_x > free_x) : dropping;
  assign rd_sum   = {1'b0, rd_index} + (AW + 1)'(xfer_count);
  assign scan_hit = (mem_rdata == 8'd0) || ((scan_idx + CW'(1)) == fill);

  always_comb begin
    state_next    = state;
    rd_index_next = rd_index;
    wr_index_next = wr_index;
    fill_next     = fill;
    dropping_next = dropping;
    work_ptr_next = work_ptr;
    rem_next      = rem;
    scan_idx_next = scan_idx;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    mem_raddr     = work_ptr;
    load          = 1'b0;
    ld_byte       = 8'd0;
    ld_status     = brb_pkg::ST_OK;
    ld_len        = '0;
    ld_last       = 1'b1;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (cmd)
            brb_pkg::CMD_WRITE: begin
              load          = 1'b1;
              dropping_next = drop_now;
              if (drop_now || full) begin
                ld_status = brb_pkg::ST_WR_REJ;
              end else begin
                mem_we        = 1'b1;
                wr_index_next = ptr_inc(wr_index);
                fill_next     = fill + CW'(1);
              end
            end
            brb_pkg::CMD_READ: begin
              if (cnt_x > fill_x || cnt_x > XW'(brb_pkg::MAX_RES)) begin
                load      = 1'b1;
                ld_status = brb_pkg::ST_RD_REJ;
              end else if (xfer_count == 6'd0) begin
                load = 1'b1;
              end else begin
                mem_re        = 1'b1;
                mem_raddr     = rd_index;
                work_ptr_next = ptr_inc(rd_index);
                rem_next      = CW'(xfer_count);
                rd_index_next = (rd_sum >= (AW + 1)'(DEPTH)) ?
                                AW'(rd_sum - (AW + 1)'(DEPTH)) : AW'(rd_sum);
                fill_next     = fill - CW'(xfer_count);
                state_next    = S_READ;
              end
            end
            brb_pkg::CMD_CLEAR: begin
              load          = 1'b1;
              rd_index_next = '0;
              wr_index_next = '0;
              fill_next     = '0;
              dropping_next = 1'b0;
            end
            brb_pkg::CMD_MEASURE: begin
              if (fill == '0) begin
                load = 1'b1;
              end else begin
                mem_re        = 1'b1;
                mem_raddr     = rd_index;
                work_ptr_next = ptr_inc(rd_index);
                scan_idx_next = '0;
                state_next    = S_SCAN;
              end
            end
          endcase
        end
      end
      S_READ: begin
        // hold the fetched byte until the output register frees up
        if (out_free) begin
          load    = 1'b1;
          ld_byte = mem_rdata;
          ld_last = (rem == CW'(1));
          if (rem == CW'(1)) begin
            state_next = S_IDLE;
          end else begin
            mem_re        = 1'b1;
            work_ptr_next = ptr_inc(work_ptr);
            rem_next      = rem - CW'(1);
          end
        end
      end
      S_SCAN: begin
        // a terminator and the end of the stored bytes both give offset + 1
        if (scan_hit) begin
          if (out_free) begin
            load       = 1'b1;
            ld_len     = scan_idx + CW'(1);
            state_next = S_IDLE;
          end
        end else begin
          mem_re        = 1'b1;
          work_ptr_next = ptr_inc(work_ptr);
          scan_idx_next = scan_idx + CW'(1);
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      store[wr_index] <= wr_byte;
    end
    if (mem_re) begin
      mem_rdata <= store[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      rd_index     <= '0;
      wr_index     <= '0;
      fill         <= '0;
      dropping     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state    <= state_next;
      rd_index <= rd_index_next;
      wr_index <= wr_index_next;
      fill     <= fill_next;
      dropping <= dropping_next;
      if (load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    work_ptr <= work_ptr_next;
    rem      <= rem_next;
    scan_idx <= scan_idx_next;
    if (load) begin
      rd_byte         <= ld_byte;
      status          <= ld_status;
      msg_len         <= 6'(ld_len);
      readable_count  <= 6'(fill_next);
      writeable_count <= 6'(CW'(DEPTH) - fill_next);
      last_of_run     <= ld_last;
    end
  end

endmodule

// File: rtl/brb_checker.sv
`timescale 1ns / 1ps

module brb_checker #(
  parameter int DEPTH = 32
) (
  input logic       clk,
  input logic       rst,
  input logic       item_stall,
  input logic       result_valid,
  input logic       result_stall,
  input logic [1:0] status,
  input logic [5:0] msg_len,
  input logic [5:0] readable_count,
  input logic [5:0] writeable_count,
  input logic       last_of_run
);

  // a stalled result must stay offered
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid)
    else $error("result dropped while stalled");

  // no new item while a finished result is held back
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |-> item_stall)
    else $error("item taken while result is held");

  // stored and free bytes always add up to the store size
  assert property (@(posedge clk) disable iff (rst)
    result_valid |-> 6'(readable_count + writeable_count) == 6'(DEPTH))
    else $error("fill counts inconsistent");

  // a rejection is a single result and carries no length
  assert property (@(posedge clk) disable iff (rst)
    result_valid && status != brb_pkg::ST_OK |-> last_of_run && msg_len == 6'd0)
    else $error("rejected item gave more than one result");

endmodule

bind byte_ring_buffer_msg_len_unit brb_checker #(.DEPTH(DEPTH)) u_brb_checker (
  .clk             (clk),
  .rst             (rst),
  .item_stall      (item_stall),
  .result_valid    (result_valid),
  .result_stall    (result_stall),
  .status          (status),
  .msg_len         (msg_len),
  .readable_count  (readable_count),
  .writeable_count (writeable_count),
  .last_of_run     (last_of_run)
);
